// ===== rtl/core/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } dq_op_t;

    // Result status carried on the output tuser.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } dq_status_t;

    // Controller states.
    typedef enum logic [0:0] {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } dq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;   // Apply the accepted request to the store and indices.
        logic load;   // Move the finished result into the output register.
    } dq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;  // Output register holds a beat that is not taken this cycle.
    } dq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Flow: an accepted request updates the indices, the count and the registered entry memory read,
// then its result is loaded into the output register; the controller takes no new request
// until that load is done, and a stalled output register holds the load back.
// While a result beat waits untaken, one more request is still accepted; the one after it
// waits until the output register frees.
// Reset (rst_n, asynchronous, active low) empties the queue; the entry memory is not cleared.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] push_word
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] pop_word, [38:32] fill_count, [39] zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    dq_pkg::dq_cmd_t    cmd;
    dq_pkg::dq_stat_t   stat;
    dq_pkg::dq_status_t status;
    logic [31:0]        pop_word;
    logic [6:0]         fill_count;

    // Request sequencing.
    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, indices and output register.
    dq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (dq_pkg::dq_op_t'(s_axis_tuser)),
        .push_word  (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .pop_word   (pop_word),
        .status     (status),
        .fill_count (fill_count)
    );

    // Pack the result beat.
    assign m_axis_tdata = {1'b0, fill_count, pop_word};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

// ===== rtl/core/dq_ctrl.sv =====
`default_nettype none

module dq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t       cmd
);

    dq_pkg::dq_state_t state_reg;
    dq_pkg::dq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: take one request, then wait until its result can be loaded.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dq_pkg::S_RESULT;
                end
            end
            dq_pkg::S_RESULT:
            begin
                if (!stat.out_stall)
                begin
                    state_next = dq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: ready only while idle, load once the output register is free.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
            end
            dq_pkg::S_RESULT:
            begin
                cmd.load = !stat.out_stall;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/dq_datapath.sv =====
`default_nettype none

module dq_datapath #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dq_pkg::dq_cmd_t cmd,
    output dq_pkg::dq_stat_t     stat,
    input  wire dq_pkg::dq_op_t  op,
    input  wire logic [31:0]     push_word,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output logic [31:0]          pop_word,
    output dq_pkg::dq_status_t   status,
    output logic [6:0]           fill_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Index and count registers.
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Entry memory with registered read.
    logic [WORD_BITS-1:0] entry_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_word_reg;

    // Result of the request in flight.
    dq_pkg::dq_status_t res_status_reg, res_status_next;
    logic               res_pop_ok_reg, res_pop_ok_next;
    logic [CNT_W-1:0]   res_count_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         pop_word_reg, pop_word_next;
    dq_pkg::dq_status_t  status_reg;
    logic [6:0]          fill_reg, fill_next;

    logic                 full;
    logic                 empty;
    logic [IDX_W-1:0]     front_inc, front_dec, back_inc, back_dec;
    logic                 wr_en, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [63:0]          push_ext;
    logic [WORD_BITS-1:0] wr_word;
    logic [63:0]          rd_ext;
    logic [31:0]          cnt_ext;

    // Wrapping neighbors of both indices.
    always_comb
    begin
        front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + IDX_W'(1);
        front_dec = (front_reg == '0) ? IDX_LAST : front_reg - IDX_W'(1);
        back_inc  = (back_reg == IDX_LAST) ? '0 : back_reg + IDX_W'(1);
        back_dec  = (back_reg == '0) ? IDX_LAST : back_reg - IDX_W'(1);
        full      = (count_reg == CNT_FULL);
        empty     = (count_reg == '0);
        push_ext  = {32'd0, push_word};
        wr_word   = push_ext[WORD_BITS-1:0];
    end

    // Request decode: one index, the count and one memory port per request.
    always_comb
    begin
        front_next      = front_reg;
        back_next       = back_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        wr_addr         = front_reg;
        rd_addr         = back_reg;
        res_status_next = dq_pkg::ST_OK;
        res_pop_ok_next = 1'b0;
        case (op)
            dq_pkg::OP_PUSH_FRONT:
            begin
                wr_addr = front_reg;
                if (full)
                begin
                    res_status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = cmd.exec;
                    front_next = front_inc;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            dq_pkg::OP_PUSH_BACK:
            begin
                wr_addr = back_dec;
                if (full)
                begin
                    res_status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = cmd.exec;
                    back_next  = back_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            dq_pkg::OP_POP_FRONT:
            begin
                rd_addr = front_dec;
                if (empty)
                begin
                    res_status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en           = cmd.exec;
                    res_pop_ok_next = 1'b1;
                    front_next      = front_dec;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                rd_addr = back_reg;
                if (empty)
                begin
                    res_status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en           = cmd.exec;
                    res_pop_ok_next = 1'b1;
                    back_next       = back_inc;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
        endcase
    end

    // Index and count registers update on each executed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Entry memory: one write or one registered read per request.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= entry_mem[rd_addr];
        end
    end

    // Capture the status and count of the request in flight.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_pop_ok_reg <= res_pop_ok_next;
            res_count_reg  <= count_next;
        end
    end

    // Format the result beat.
    always_comb
    begin
        rd_ext        = 64'(rd_word_reg);
        cnt_ext       = 32'(res_count_reg);
        pop_word_next = res_pop_ok_reg ? rd_ext[31:0] : 32'd0;
        fill_next     = cnt_ext[6:0];
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pop_word_reg <= pop_word_next;
            status_reg   <= res_status_reg;
            fill_reg     <= fill_next;
        end
    end

    assign stat.out_stall = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign pop_word       = pop_word_reg;
    assign status         = status_reg;
    assign fill_count     = fill_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dq_checker.sv =====
`default_nettype none

module dq_checker #(
    parameter int DEPTH = 64
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
    else $error("Stalled result beat changed.");

    // Only one request is in flight: no request is taken right after another.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Request accepted while another is in flight.");

    // An empty flag comes with a zero fill count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == dq_pkg::ST_EMPTY |-> m_axis_tdata[38:32] == 7'd0)
    else $error("Empty status with nonzero fill count.");

    // A full flag comes with the fill count of a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == dq_pkg::ST_FULL |-> m_axis_tdata[38:32] == 7'(DEPTH))
    else $error("Full status with wrong fill count.");

    // A flagged request returns no word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != dq_pkg::ST_OK |-> m_axis_tdata[31:0] == 32'd0)
    else $error("Flagged request returned a word.");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== dv/tb_double_ended_queue.sv =====
`default_nettype none

module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int DIRECTED_LEN = 20;

    // One result as the master side should present it.
    typedef struct {
        logic [31:0]        pop_word;
        dq_pkg::dq_status_t status;
        logic [6:0]         fill;
    } deque_result_t;

    // One request, with a hand-written result where it is obvious.
    typedef struct {
        dq_pkg::dq_op_t op;
        logic [31:0]    word;
        bit             typed;
        deque_result_t  want;
    } request_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Shadow copy of the deque, kept by the predictor.
    logic [31:0] shadow_slots [DEPTH];
    logic [5:0]  front_slot  = '0;
    logic [5:0]  back_slot   = '0;
    logic [6:0]  shadow_held = '0;

    request_row_t  request_notes [$];
    deque_result_t expected_results [$];
    request_row_t  directed_rows [DIRECTED_LEN];

    bit idle_on      = 1'b0;
    int stall_left   = 0;
    int mismatch_count = 0;
    int push_count   = 0;
    int pop_count    = 0;
    int full_hits    = 0;
    int empty_hits   = 0;
    int peak_fill    = 0;

    double_ended_queue #(
        .DEPTH     (DEPTH),
        .WORD_BITS (32)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] push_word
        .s_axis_tuser  (s_axis_tuser),   // [1:0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] pop_word, [38:32] fill_count, [39] zero
        .m_axis_tuser  (m_axis_tuser)    // [1:0] status
    );

    // Free-running clock with a 10 ns period.
    always #5 clk = ~clk;

    // Applies one request to the shadow deque and returns its result.
    // The 6-bit slot pointers wrap modulo the depth on their own.
    function automatic deque_result_t apply_request(input dq_pkg::dq_op_t op,
                                                    input logic [31:0] word);
        deque_result_t res;
        res.pop_word = '0;
        res.status   = dq_pkg::ST_OK;
        case (op)
            dq_pkg::OP_PUSH_FRONT:
            begin
                if (shadow_held == 7'(DEPTH))
                begin
                    res.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    shadow_slots[front_slot] = word;
                    front_slot  = front_slot + 6'd1;
                    shadow_held = shadow_held + 7'd1;
                end
            end
            dq_pkg::OP_PUSH_BACK:
            begin
                if (shadow_held == 7'(DEPTH))
                begin
                    res.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    back_slot = back_slot - 6'd1;
                    shadow_slots[back_slot] = word;
                    shadow_held = shadow_held + 7'd1;
                end
            end
            dq_pkg::OP_POP_FRONT:
            begin
                if (shadow_held == 7'd0)
                begin
                    res.status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    front_slot   = front_slot - 6'd1;
                    res.pop_word = shadow_slots[front_slot];
                    shadow_held  = shadow_held - 7'd1;
                end
            end
            default:
            begin
                if (shadow_held == 7'd0)
                begin
                    res.status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.pop_word = shadow_slots[back_slot];
                    back_slot    = back_slot + 6'd1;
                    shadow_held  = shadow_held - 7'd1;
                end
            end
        endcase
        res.fill = shadow_held;
        return res;
    endfunction

    // Drives one request beat, with an optional idle burst ahead of it.
    task automatic send_request(input request_row_t row);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        request_notes = {request_notes, row};
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.op;
        s_axis_tdata  <= row.word;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Sends a random request that is a push with the given percent chance.
    task automatic send_mixed(input int push_pct);
        request_row_t row;
        if ($urandom_range(0, 99) < push_pct)
            row.op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
        else
            row.op = $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
        case ($urandom_range(0, 7))
            0:       row.word = '0;
            1:       row.word = '1;
            default: row.word = $urandom;
        endcase
        row.typed = 1'b0;
        send_request(row);
    endtask

    // While idle gaps are on, the result side stalls in random bursts.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left    <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Checks each result beat, then predicts the result of each accepted request beat.
    always @(posedge clk)
    begin
        deque_result_t got;
        deque_result_t want;
        request_row_t  note;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pop_word = m_axis_tdata[31:0];
                got.fill     = m_axis_tdata[38:32];
                got.status   = dq_pkg::dq_status_t'(m_axis_tuser);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: word %h status %0d fill %0d",
                             $time, got.pop_word, got.status, got.fill);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.pop_word !== want.pop_word)
                    begin
                        $display("%0t: pop_word expected %h, got %h",
                                 $time, want.pop_word, got.pop_word);
                        mismatch_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.fill !== want.fill)
                    begin
                        $display("%0t: fill_count expected %0d, got %0d",
                                 $time, want.fill, got.fill);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[39] !== 1'b0)
                    begin
                        $display("%0t: tdata pad bit expected 0, got %b",
                                 $time, m_axis_tdata[39]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                note = request_notes[0];
                request_notes.delete(0);
                want = apply_request(dq_pkg::dq_op_t'(s_axis_tuser), s_axis_tdata);
                if (want.status == dq_pkg::ST_FULL)
                    full_hits++;
                else if (want.status == dq_pkg::ST_EMPTY)
                    empty_hits++;
                if (s_axis_tuser[1])
                    pop_count++;
                else
                    push_count++;
                if (int'(want.fill) > peak_fill)
                    peak_fill = int'(want.fill);
                expected_results = {expected_results, (note.typed ? note.want : want)};
            end
        end
    end

    // Stimulus: directed table, a fill-to-full and drain-to-empty sweep, random mixes.
    initial
    begin
        int random_sent;
        int seg_len;
        int push_pct;
        int drain_wait;

        // Obvious results are typed in; the rest come from the predictor.
        directed_rows = '{
            '{dq_pkg::OP_POP_FRONT,  32'hDEAD_BEEF, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 7'd0}},
            '{dq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 7'd0}},
            '{dq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0, dq_pkg::ST_OK,    7'd1}},
            '{dq_pkg::OP_POP_FRONT,  32'h1234_5678, 1'b1, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{32'h0, dq_pkg::ST_OK,    7'd1}},
            '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1,
              '{32'hFFFF_FFFF, dq_pkg::ST_OK, 7'd0}},
            '{dq_pkg::OP_PUSH_BACK,  32'h7F80_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_PUSH_BACK,  32'h0000_0001, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_BACK,   32'hAAAA_AAAA, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_BACK,   32'h5555_5555, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 7'd0}},
            '{dq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    7'd0}},
            '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 7'd0}}
        };

        // Reset is held low from time zero and released at a clock edge.
        repeat (12) @(posedge clk);
        rst_n   <= 1'b1;
        idle_on = 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // Overfill from any level to hit the full case, then drain past empty.
        repeat (70) send_mixed(100);
        repeat (70) send_mixed(0);

        // Random segments that lean toward filling, draining or staying level.
        random_sent = 0;
        while (random_sent < 200)
        begin
            seg_len = $urandom_range(15, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (seg_len) send_mixed(push_pct);
            random_sent += seg_len;
        end

        // The closing stretch runs back to back on both sides.
        idle_on = 1'b0;
        repeat (60) send_mixed(50);
        s_axis_tvalid <= 1'b0;

        // Wait for the last results, and let any stray beat show before the final check.
        drain_wait = 0;
        while (expected_results.size() != 0 && drain_wait < 2000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (5) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            mismatch_count++;
        end

        $display("Sent %0d requests: %0d pushes and %0d pops.", push_count + pop_count,
                 push_count, pop_count);
        $display("Saw %0d full and %0d empty rejections; peak fill %0d of %0d.",
                 full_hits, empty_hits, peak_fill, DEPTH);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
